// ===== rtl/anb_pkg.sv =====
package anb_pkg;

  // Look-ahead window depth in bytes.
  localparam int WIN_DEPTH = 5;
  // Bytes needed in the window before a start code can be judged.
  localparam int MIN_LOOK = 4;

  localparam int CFG_BITS = 24;
  localparam logic [CFG_BITS-1:0] MAX_PACKET_RESET = 24'd4096;

  localparam int STAMP_OUT_BITS = 32;

  typedef logic [7:0] byte_t;
  typedef byte_t [WIN_DEPTH-1:0] win_t;

  localparam byte_t SC_ZERO = 8'h00;
  localparam byte_t SC_ONE = 8'h01;
  localparam logic [2:0] SC_LONG_LEN = 3'd4;
  localparam logic [2:0] SC_SHORT_LEN = 3'd3;

  localparam byte_t NAL_TYPE_MASK = 8'h1f;
  localparam byte_t NAL_SLICE = 8'd1;
  localparam byte_t NAL_SLICE_IDR = 8'd5;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_START = 2'd1,
    ERR_ADJACENT = 2'd2,
    ERR_END_CODE = 2'd3
  } err_code_t;

  typedef struct packed {
    logic                      byte_valid;
    byte_t                     out_byte;
    logic                      packet_first;
    logic                      packet_final;
    logic                      unit_first;
    logic                      unit_final;
    logic                      stamp_valid;
    logic [STAMP_OUT_BITS-1:0] stamp;
    err_code_t                 error_code;
    logic                      stream_done;
    logic                      last_result;
  } result_t;

endpackage

// ===== rtl/anb_in_if.sv =====
interface anb_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

// ===== rtl/anb_out_if.sv =====
interface anb_out_if import anb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      byte_valid;
  logic [7:0]                out_byte;
  logic                      packet_first;
  logic                      packet_final;
  logic                      unit_first;
  logic                      unit_final;
  logic                      stamp_valid;
  logic [STAMP_OUT_BITS-1:0] stamp;
  err_code_t                 error_code;
  logic                      stream_done;
  logic                      last_result;

  modport source (
    output valid, output byte_valid, output out_byte, output packet_first,
    output packet_final, output unit_first, output unit_final, output stamp_valid,
    output stamp, output error_code, output stream_done, output last_result,
    input ready
  );
  modport sink (
    input valid, input byte_valid, input out_byte, input packet_first,
    input packet_final, input unit_first, input unit_final, input stamp_valid,
    input stamp, input error_code, input stream_done, input last_result,
    output ready
  );
endinterface

// ===== rtl/annexb_nal_packetizer.sv =====
// Annex B NAL packetizer.
// The stream channel takes one request per byte: mode 0 carries data_byte, mode 1
// marks end of stream. The packets channel returns results in order, one per
// cycle while the receiver is ready, each a passed-through byte with packet, unit
// and frame stamp marks, or a closing result with an error code or stream_done.
// last_result marks the final result caused by one request. cfg_we/cfg_wdata set
// the packet size limit. A result is written into the two-entry output queue when
// its request is taken and is visible on packets in the next cycle. A request
// that causes zero or one result is done when taken, so ordinary payload bytes
// flow at one per cycle while the queue has space. A request that causes several
// results, as a start code burst or end of stream flush does, holds the stream
// channel until its last result is queued, at one a cycle while there is space.
// Reset empties the window and the output queue, clears the stamp counter and
// loads the packet size limit with 4096. When the receiver stalls, the queue
// fills and stream.ready drops until a result is taken. After an error or the
// end of stream the block keeps taking requests but gives no results until reset.
module annexb_nal_packetizer import anb_pkg::*; #(
  parameter int PACKET_SIZE_BITS = 24,
  parameter int STAMP_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  anb_in_if.sink              stream,
  anb_out_if.source           packets
);

  localparam int FILL_BITS = $clog2(WIN_DEPTH + 1);

  typedef logic [FILL_BITS-1:0] fill_t;

  typedef struct packed {
    win_t                        win;
    fill_t                       fill;
    logic                        in_unit;
    logic [2:0]                  sc_len;
    logic [1:0]                  sc_cnt;
    logic                        first_packet;
    logic [PACKET_SIZE_BITS-1:0] packet_fill;
    logic [STAMP_BITS-1:0]       stamp_cnt;
    logic                        halted;
  } state_t;

  // Length of a start code at window position 0 or 1, given avail known bytes.
  function automatic logic [2:0] code_len(input win_t w, input logic pos, input fill_t avail);
    byte_t      c0, c1, c2, c3;
    logic [2:0] len;
    c0 = pos ? w[1] : w[0];
    c1 = pos ? w[2] : w[1];
    c2 = pos ? w[3] : w[2];
    c3 = pos ? w[4] : w[3];
    len = '0;
    if (int'(pos) + int'(avail) <= WIN_DEPTH) begin
      if (avail >= fill_t'(MIN_LOOK) && c0 == SC_ZERO && c1 == SC_ZERO &&
          c2 == SC_ZERO && c3 == SC_ONE) begin
        len = SC_LONG_LEN;
      end else if (avail >= fill_t'(SC_SHORT_LEN) && c0 == SC_ZERO && c1 == SC_ZERO &&
                   c2 == SC_ONE) begin
        len = SC_SHORT_LEN;
      end
    end
    return len;
  endfunction

  // True when the state would give one more result within the same request.
  function automatic logic will_emit(input state_t s, input logic eos);
    logic [2:0] len;
    fill_t      left;
    logic       r;
    len = code_len(s.win, 1'b0, s.fill);
    left = s.fill - fill_t'(len);
    if (s.halted) begin
      r = 1'b0;
    end else if (!s.in_unit) begin
      if (s.fill == '0) begin
        r = eos;
      end else if (!eos && s.fill < fill_t'(MIN_LOOK)) begin
        r = 1'b0;
      end else if (len == '0) begin
        r = 1'b1;
      end else begin
        r = eos || left >= fill_t'(MIN_LOOK);
      end
    end else if (s.sc_len != '0) begin
      r = (s.sc_cnt != '0) || eos || s.fill >= fill_t'(MIN_LOOK);
    end else if (s.fill == '0) begin
      r = eos;
    end else begin
      r = eos || s.fill == fill_t'(WIN_DEPTH);
    end
    return r;
  endfunction

  state_t                      st;
  state_t                      cur;
  state_t                      aft;
  state_t                      st_next;
  logic                        busy;
  logic                        step_eos;
  logic [CFG_BITS-1:0]         max_packet_bytes;

  logic                        eos;
  logic                        emit;
  result_t                     res;
  logic [2:0]                  len0;
  logic                        sc_begin;
  logic                        sc_more;
  logic                        pb_do;
  byte_t                       pb_byte;
  logic                        pb_last;
  logic                        pb_sv;
  logic [STAMP_BITS-1:0]       pb_stamp;
  logic                        last_b;
  byte_t                       nal_type;
  logic                        slice;
  logic [PACKET_SIZE_BITS-1:0] limit;
  logic [PACKET_SIZE_BITS-1:0] inc;
  logic                        pf;
  logic                        uf;
  logic                        fin;

  result_t                     fifo_mem [2];
  logic                        wptr;
  logic                        rptr;
  logic [1:0]                  count;
  logic                        space;
  logic                        go;
  logic                        push;
  logic                        pop;

  assign space = count != 2'd2;
  assign stream.ready = !busy && space;
  assign go = busy ? space : (stream.valid && space);
  assign push = go && emit;
  assign pop = packets.valid && packets.ready;

  always_comb begin
    eos = busy ? step_eos : stream.mode;

    // Load the new byte into the window when a request starts.
    cur = st;
    if (!busy && !stream.mode && st.fill < fill_t'(WIN_DEPTH)) begin
      cur.win[st.fill] = stream.data_byte;
      cur.fill = st.fill + fill_t'(1);
    end

    st_next = cur;
    emit = 1'b0;
    res = '0;
    sc_begin = 1'b0;
    sc_more = 1'b0;
    pb_do = 1'b0;
    pb_byte = '0;
    pb_last = 1'b0;
    pb_sv = 1'b0;
    pb_stamp = '0;
    last_b = 1'b0;
    nal_type = '0;
    slice = 1'b0;
    limit = '0;
    inc = '0;
    pf = 1'b0;
    uf = 1'b0;
    fin = 1'b0;

    // State right after a leading start code is consumed.
    len0 = code_len(cur.win, 1'b0, cur.fill);
    aft = cur;
    aft.win = cur.win >> {len0, 3'b000};
    aft.fill = cur.fill - fill_t'(len0);
    aft.in_unit = 1'b1;
    aft.sc_len = len0;
    aft.sc_cnt = '0;

    if (cur.halted) begin
      st_next = cur;
    end else if (!cur.in_unit) begin
      if (cur.fill == '0) begin
        if (eos) begin
          emit = 1'b1;
          res.stream_done = 1'b1;
          st_next.halted = 1'b1;
        end
      end else if (!eos && cur.fill < fill_t'(MIN_LOOK)) begin
        st_next = cur;
      end else if (len0 == '0) begin
        emit = 1'b1;
        res.error_code = ERR_NO_START;
        st_next.halted = 1'b1;
      end else begin
        st_next = aft;
        sc_begin = 1'b1;
      end
    end else if (cur.sc_len != '0) begin
      if (cur.sc_cnt != '0) begin
        sc_more = 1'b1;
      end else begin
        sc_begin = 1'b1;
      end
    end else begin
      if (cur.fill == '0) begin
        st_next.in_unit = 1'b0;
        if (eos) begin
          emit = 1'b1;
          res.stream_done = 1'b1;
          st_next.halted = 1'b1;
        end
      end else if (eos || cur.fill == fill_t'(WIN_DEPTH)) begin
        // A payload byte ends its unit when a start code or end of stream follows it.
        last_b = (cur.fill == fill_t'(1)) ||
                 (code_len(cur.win, 1'b1, cur.fill - fill_t'(1)) != '0);
        pb_do = 1'b1;
        pb_byte = cur.win[0];
        pb_last = last_b;
        st_next.win = cur.win >> 8;
        st_next.fill = cur.fill - fill_t'(1);
        if (last_b) begin
          st_next.in_unit = 1'b0;
        end
      end
    end

    // Start code bytes go out once payload follows, else an end or adjacent error.
    if (sc_begin) begin
      if (!eos && st_next.fill < fill_t'(MIN_LOOK)) begin
        sc_more = 1'b0;
      end else if (st_next.fill == '0) begin
        emit = 1'b1;
        res.error_code = ERR_END_CODE;
        st_next.halted = 1'b1;
      end else if (code_len(st_next.win, 1'b0, st_next.fill) != '0) begin
        emit = 1'b1;
        res.error_code = ERR_ADJACENT;
        st_next.halted = 1'b1;
      end else begin
        nal_type = st_next.win[0] & NAL_TYPE_MASK;
        slice = (nal_type == NAL_SLICE) || (nal_type == NAL_SLICE_IDR);
        pb_sv = slice;
        pb_stamp = st_next.stamp_cnt;
        if (slice) begin
          st_next.stamp_cnt = st_next.stamp_cnt + STAMP_BITS'(1);
        end
        st_next.first_packet = 1'b1;
        st_next.packet_fill = '0;
        sc_more = 1'b1;
      end
    end

    if (sc_more) begin
      pb_do = 1'b1;
      if ({1'b0, st_next.sc_cnt} + 3'd1 == st_next.sc_len) begin
        pb_byte = SC_ONE;
        st_next.sc_len = '0;
        st_next.sc_cnt = '0;
      end else begin
        pb_byte = SC_ZERO;
        st_next.sc_cnt = st_next.sc_cnt + 2'd1;
      end
    end

    if (pb_do) begin
      limit = PACKET_SIZE_BITS'(max_packet_bytes);
      if (limit == '0) begin
        limit = PACKET_SIZE_BITS'(1);
      end
      pf = st_next.packet_fill == '0;
      uf = pf && st_next.first_packet;
      inc = st_next.packet_fill + PACKET_SIZE_BITS'(1);
      fin = pb_last || inc >= limit;
      emit = 1'b1;
      res.byte_valid = 1'b1;
      res.out_byte = pb_byte;
      res.packet_first = pf;
      res.packet_final = fin;
      res.unit_first = uf;
      res.unit_final = fin && pb_last;
      res.stamp_valid = uf && pb_sv;
      res.stamp = (uf && pb_sv) ? STAMP_OUT_BITS'(pb_stamp) : '0;
      st_next.packet_fill = fin ? '0 : inc;
      if (fin) begin
        st_next.first_packet = 1'b0;
      end
    end

    res.last_result = !will_emit(st_next, eos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      busy <= 1'b0;
      step_eos <= 1'b0;
      max_packet_bytes <= MAX_PACKET_RESET;
      count <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_packet_bytes <= cfg_wdata;
      end
      if (go) begin
        st <= st_next;
        busy <= emit && !res.last_result;
        step_eos <= eos;
      end
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wptr] <= res;
    end
  end

  assign packets.valid = count != '0;
  assign packets.byte_valid = fifo_mem[rptr].byte_valid;
  assign packets.out_byte = fifo_mem[rptr].out_byte;
  assign packets.packet_first = fifo_mem[rptr].packet_first;
  assign packets.packet_final = fifo_mem[rptr].packet_final;
  assign packets.unit_first = fifo_mem[rptr].unit_first;
  assign packets.unit_final = fifo_mem[rptr].unit_final;
  assign packets.stamp_valid = fifo_mem[rptr].stamp_valid;
  assign packets.stamp = fifo_mem[rptr].stamp;
  assign packets.error_code = fifo_mem[rptr].error_code;
  assign packets.stream_done = fifo_mem[rptr].stream_done;
  assign packets.last_result = fifo_mem[rptr].last_result;

endmodule

// ===== rtl/anb_checker.sv =====
module anb_checker import anb_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      valid,
  input logic      ready,
  input logic      byte_valid,
  input logic      packet_first,
  input logic      packet_final,
  input logic      unit_first,
  input logic      unit_final,
  input logic      stamp_valid,
  input err_code_t error_code,
  input logic      stream_done,
  input logic      last_result
);

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("packets.valid dropped while a result was stalled");

  // A result without a byte is an error or the end of stream, and closes its request.
  a_closing: assert property (@(posedge clk) disable iff (rst)
    valid && !byte_valid |-> last_result && (stream_done || error_code != ERR_NONE))
    else $error("result without a byte is neither error nor stream end");

  // Nothing follows an error or the end of stream.
  a_silent: assert property (@(posedge clk) disable iff (rst)
    valid && ready && (stream_done || error_code != ERR_NONE) |=> !valid)
    else $error("result offered after an error or stream end");

  a_unit_final: assert property (@(posedge clk) disable iff (rst)
    valid && unit_final |-> packet_final && byte_valid)
    else $error("unit end mark on a byte that does not end a packet");

  a_stamp: assert property (@(posedge clk) disable iff (rst)
    valid && stamp_valid |-> unit_first && packet_first)
    else $error("frame stamp outside the first byte of a unit");

endmodule

bind annexb_nal_packetizer anb_checker u_anb_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (packets.valid),
  .ready        (packets.ready),
  .byte_valid   (packets.byte_valid),
  .packet_first (packets.packet_first),
  .packet_final (packets.packet_final),
  .unit_first   (packets.unit_first),
  .unit_final   (packets.unit_final),
  .stamp_valid  (packets.stamp_valid),
  .error_code   (packets.error_code),
  .stream_done  (packets.stream_done),
  .last_result  (packets.last_result)
);
